@@ rtl/fpbcd_pkg.sv @@
// Shared types, constants and helper functions for the hertz / packed BCD converter.
// No dependencies; every other file in rtl/ imports this package.

package fpbcd_pkg;

   // conversion direction
   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_DECODE = 1'b1
   } cmd_type;

   // input word
   typedef struct packed {
      cmd_type     command;
      logic [31:0] freq_hz;
      logic [31:0] bcd_in;
   } req_type;

   // result word
   typedef struct packed {
      logic [31:0] bcd_out;
      logic [30:0] freq_out;
      logic        digits_overflow;
      logic        bad_digit;
   } rsp_type;

   // register stages: input, four working stages, result
   localparam int NUM_STAGES = 6;

   // stage load enables and stage occupancy
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } pipe_ctl_type;

   // encode side result: four base-100 digit pairs, most significant first
   typedef struct packed {
      logic [3:0][6:0] pair;
      logic            overflow;
   } enc_out_type;

   // decode side result
   typedef struct packed {
      logic [30:0] freq;
      logic        bad;
   } dec_out_type;

   // divide by ten: x * RECIP_DIV10 >> 35, exact for any 32-bit x
   localparam logic [31:0] RECIP_DIV10  = 32'hCCCC_CCCD;
   // quotient limits for the eight-digit window
   localparam logic [28:0] DIGIT_LIMIT1 = 29'd100000000;
   localparam logic [28:0] DIGIT_LIMIT2 = 29'd200000000;
   localparam logic [28:0] DIGIT_LIMIT3 = 29'd300000000;
   localparam logic [28:0] DIGIT_LIMIT4 = 29'd400000000;
   // reciprocals for x below 10^8: >> 47 gives x / 10^6, >> 40 gives x / 10^4,
   // >> 32 gives x / 100
   localparam logic [27:0] RECIP_DIV1E6 = 28'd140737489;
   localparam logic [26:0] RECIP_DIV1E4 = 27'd109951163;
   localparam logic [25:0] RECIP_DIV100 = 26'd42949673;

   // two BCD digits of a value below one hundred
   function automatic logic [7:0] bcd_pair(input logic [6:0] v);
      logic [16:0] p;
      logic [3:0]  tens;
      logic [6:0]  ones;
      p    = 17'(v) * 17'd103;
      tens = p[13:10];
      ones = v - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

endpackage

@@ rtl/fpbcd_ctrl.sv @@
// Stage occupancy and load enables for the converter pipeline.
// Depends on fpbcd_pkg (pipe_ctl_type, NUM_STAGES).

module fpbcd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_ready,
   output fpbcd_pkg::pipe_ctl_type ctl
);
   import fpbcd_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] load;

   // a stage loads when empty or when the stage after it moves on
   always_comb begin
      load[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   // occupancy moves along with the data
   always_comb begin
      valid_in[0] = load[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.load  = load;
   assign ctl.valid = valid_ff;

endmodule

@@ rtl/fpbcd_encode.sv @@
// Hertz to base-100 digit pairs: divide by ten, fold into eight digits, split.
// Depends on fpbcd_pkg (constants, pipe_ctl_type, enc_out_type).

module fpbcd_encode (
   input  logic                    clock,
   input  fpbcd_pkg::pipe_ctl_type ctl,
   input  logic [31:0]             freq_hz,
   output fpbcd_pkg::enc_out_type  enc
);
   import fpbcd_pkg::*;

   logic [63:0] prod10;
   logic [28:0] units_ff, units_in;
   logic [28:0] sub_val;
   logic [26:0] rest_ff, rest_in;
   logic        ovf3_ff, ovf_in;
   logic [54:0] prod6;
   logic [53:0] prod4;
   logic [52:0] prod2;
   logic [6:0]  q6_ff;
   logic [13:0] q4_ff;
   logic [19:0] q2_ff;
   logic [26:0] rest4_ff;
   logic        ovf4_ff;
   logic [3:0][6:0] pair_ff, pair_in;
   logic        ovf5_ff;

   // stage 2: units of ten hertz
   assign prod10   = 64'(freq_hz) * 64'(RECIP_DIV10);
   assign units_in = prod10[63:35];

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         units_ff <= units_in;
      end
   end

   // stage 3: keep the low eight digits, flag the rest
   always_comb begin
      if (units_ff >= DIGIT_LIMIT4) begin
         sub_val = DIGIT_LIMIT4;
      end else if (units_ff >= DIGIT_LIMIT3) begin
         sub_val = DIGIT_LIMIT3;
      end else if (units_ff >= DIGIT_LIMIT2) begin
         sub_val = DIGIT_LIMIT2;
      end else if (units_ff >= DIGIT_LIMIT1) begin
         sub_val = DIGIT_LIMIT1;
      end else begin
         sub_val = '0;
      end
      rest_in = 27'(units_ff - sub_val);
      ovf_in  = units_ff >= DIGIT_LIMIT1;
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         rest_ff <= rest_in;
         ovf3_ff <= ovf_in;
      end
   end

   // stage 4: quotients by 10^6, 10^4 and 100
   assign prod6 = 55'(rest_ff) * 55'(RECIP_DIV1E6);
   assign prod4 = 54'(rest_ff) * 54'(RECIP_DIV1E4);
   assign prod2 = 53'(rest_ff) * 53'(RECIP_DIV100);

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         q6_ff    <= prod6[53:47];
         q4_ff    <= prod4[53:40];
         q2_ff    <= prod2[51:32];
         rest4_ff <= rest_ff;
         ovf4_ff  <= ovf3_ff;
      end
   end

   // stage 5: base-100 digits from neighboring quotients
   always_comb begin
      pair_in[3] = q6_ff;
      pair_in[2] = 7'(q4_ff - 14'(q6_ff) * 14'd100);
      pair_in[1] = 7'(q2_ff - 20'(q4_ff) * 20'd100);
      pair_in[0] = 7'(rest4_ff - 27'(q2_ff) * 27'd100);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         pair_ff <= pair_in;
         ovf5_ff <= ovf4_ff;
      end
   end

   assign enc.pair     = pair_ff;
   assign enc.overflow = ovf5_ff;

endmodule

@@ rtl/fpbcd_decode.sv @@
// Packed BCD to hertz: weight nibbles by place, combine halves, scale by ten.
// Depends on fpbcd_pkg (pipe_ctl_type, dec_out_type).

module fpbcd_decode (
   input  logic                    clock,
   input  fpbcd_pkg::pipe_ctl_type ctl,
   input  logic [31:0]             bcd_in,
   output fpbcd_pkg::dec_out_type  dec
);
   import fpbcd_pkg::*;

   logic [7:0][3:0] nib;
   logic [14:0] hi_in, lo_in;
   logic        bad_in;
   logic [14:0] hi_ff, lo_ff;
   logic        bad2_ff;
   logic [27:0] sum_ff, sum_in;
   logic        bad3_ff;
   logic [30:0] freq4_ff, freq_in;
   logic        bad4_ff;
   logic [30:0] freq5_ff;
   logic        bad5_ff;

   assign nib = bcd_in;

   // stage 2: four-digit halves and digit check
   always_comb begin
      hi_in = 15'(nib[7]) * 15'd1000 + 15'(nib[6]) * 15'd100
            + 15'(nib[5]) * 15'd10 + 15'(nib[4]);
      lo_in = 15'(nib[3]) * 15'd1000 + 15'(nib[2]) * 15'd100
            + 15'(nib[1]) * 15'd10 + 15'(nib[0]);
      bad_in = 1'b0;
      for (int i = 0; i < 8; i++) begin
         bad_in = bad_in | (nib[i] > 4'd9);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         bad2_ff <= bad_in;
      end
   end

   // stage 3: join halves
   assign sum_in = 28'(hi_ff) * 28'd10000 + 28'(lo_ff);

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         sum_ff  <= sum_in;
         bad3_ff <= bad2_ff;
      end
   end

   // stage 4: scale to hertz, worst case still fits 31 bits
   assign freq_in = 31'(sum_ff) * 31'd10;

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         freq4_ff <= freq_in;
         bad4_ff  <= bad3_ff;
      end
   end

   // stage 5: align with the encode side
   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         freq5_ff <= freq4_ff;
         bad5_ff  <= bad4_ff;
      end
   end

   assign dec.freq = freq5_ff;
   assign dec.bad  = bad5_ff;

endmodule

@@ rtl/freq_packed_bcd_convert_core.sv @@
// Top level of the hertz / packed BCD converter: input register, pipeline, result register.
// Depends on fpbcd_pkg, fpbcd_ctrl, fpbcd_encode and fpbcd_decode.
//
// Usage:
//   req channel (req_valid / req_ready / req_data) takes one word per cycle while req_ready is high.
//   command CMD_ENCODE turns freq_hz into eight packed BCD digits of freq_hz / 10,
//   dropping digits above the eighth and raising digits_overflow. CMD_DECODE
//   turns bcd_in into hertz (digit value times ten), raising bad_digit when a
//   nibble is above nine; such nibbles are still weighted by their value.
//   Fields of the other direction read zero.
//   rsp channel (rsp_valid / rsp_ready / rsp_data) returns exactly one word per
//   request, in order.
//   Pipeline: six register stages, the input register, four working stages
//   and the result register. Throughput: one word per cycle while the
//   receiver keeps rsp_ready high.
//   Stall: when rsp_ready is low the pipeline keeps filling its empty stages
//   and req_ready stays high until all six stages hold a word; nothing is lost.
//   Reset: synchronous, clears all stage valid bits; the data registers are not
//   reset, and the block is ready for a request on the first cycle after reset.

module freq_packed_bcd_convert_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fpbcd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output fpbcd_pkg::rsp_type rsp_data
);
   import fpbcd_pkg::*;

   pipe_ctl_type ctl;
   req_type      req_ff;
   cmd_type      cmd_ff [4];
   rsp_type      rsp_ff, rsp_in;
   enc_out_type  enc;
   dec_out_type  dec;

   // pipeline control
   fpbcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   // input register
   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         req_ff <= req_data;
      end
   end

   // command follows its word through the working stages
   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         cmd_ff[0] <= req_ff.command;
      end
      for (int i = 1; i < 4; i++) begin
         if (ctl.load[i+1]) begin
            cmd_ff[i] <= cmd_ff[i-1];
         end
      end
   end

   fpbcd_encode u_encode (
      .clock   (clock),
      .ctl     (ctl),
      .freq_hz (req_ff.freq_hz),
      .enc     (enc)
   );

   fpbcd_decode u_decode (
      .clock  (clock),
      .ctl    (ctl),
      .bcd_in (req_ff.bcd_in),
      .dec    (dec)
   );

   // result select, unused direction reads zero
   always_comb begin
      rsp_in = '0;
      case (cmd_ff[3])
         CMD_ENCODE: begin
            rsp_in.bcd_out = {bcd_pair(enc.pair[3]), bcd_pair(enc.pair[2]),
                              bcd_pair(enc.pair[1]), bcd_pair(enc.pair[0])};
            rsp_in.digits_overflow = enc.overflow;
         end
         CMD_DECODE: begin
            rsp_in.freq_out  = dec.freq;
            rsp_in.bad_digit = dec.bad;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctl.load[NUM_STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = ctl.load[0];
   assign rsp_valid = ctl.valid[NUM_STAGES-1];
   assign rsp_data  = rsp_ff;

   // a full pipeline with a stalled receiver takes nothing new
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (ctl.valid == '1 && !rsp_ready) |-> !req_ready)
      else $error("request taken while pipeline full and stalled");

   // an accepted word occupies the input stage next cycle
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ctl.valid[0])
      else $error("accepted word missing from input stage");

   // encode and decode flags never appear together
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.digits_overflow && rsp_data.bad_digit))
      else $error("both direction flags set");

   // a decode result carries no encode digits
   a_dir_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.freq_out != '0) |-> (rsp_data.bcd_out == '0))
      else $error("decode result has encode digits");

endmodule
